// File: hdl/lbpih_pkg.sv
package lbpih_pkg;

  localparam int PIX_W     = 8;
  localparam int BIN_W     = 8;
  localparam int COORD_W   = 10;
  localparam int CNT_W     = 20;
  localparam int DIM_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int HIST_BINS = 256;
  localparam int QUEUE_DEPTH = 2;
  localparam int WIN_TAPS  = 6;

  localparam logic [CNT_W-1:0] HIST_MAX = 20'hFFFFF;
  localparam int DIM_MIN   = 3;
  localparam int DIM_RESET = 10;

  // input opcodes
  localparam logic [1:0] OP_PIXEL = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

  // result kinds
  localparam logic RESULT_CODE = 1'b0;
  localparam logic RESULT_BIN  = 1'b1;

  typedef enum logic [1:0] {
    K_PIXEL,
    K_READ,
    K_CLEAR
  } kind_e;

  // request as classified by the front end
  typedef struct packed {
    kind_e              kind;
    logic [PIX_W-1:0]   px;
    logic [BIN_W-1:0]   bin;
    logic               border;
    logic               emit;
    logic               last;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } item_t;

endpackage

// File: hdl/lbpih_ram.sv
module lbpih_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/lbpih_fifo.sv
module lbpih_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW:0]      wptr_q, wptr_d;
  logic [AW:0]      rptr_q, rptr_d;
  logic             full, empty;

  assign empty   = (wptr_q == rptr_q);
  assign full    = (wptr_q[AW] != rptr_q[AW]) && (wptr_q[AW-1:0] == rptr_q[AW-1:0]);
  assign ready_o = !full;
  assign valid_o = !empty;
  assign rdata_o = mem_q[rptr_q[AW-1:0]];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (push_i && !full) begin
      wptr_d = wptr_q + 1'b1;
    end
    if (pop_i && !empty) begin
      rptr_d = rptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full) begin
      mem_q[wptr_q[AW-1:0]] <= wdata_i;
    end
  end

endmodule

// File: hdl/lbpih_front.sv
module lbpih_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lbpih_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lbpih_pkg::DIM_W-1:0]        cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         opcode_i,
  input  logic [lbpih_pkg::PIX_W-1:0]        pixel_value_i,
  input  logic [lbpih_pkg::BIN_W-1:0]        bin_index_i,
  input  logic                               q_ready_i,
  output logic                               q_push_o,
  output lbpih_pkg::item_t                   q_item_o,
  output logic [$clog2(MAX_WIDTH)-1:0]       q_ci_o
);

  import lbpih_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WDW = $clog2(MAX_WIDTH + 1);
  localparam int HDW = $clog2(MAX_HEIGHT + 1);
  localparam int W_RST = (DIM_RESET < MAX_WIDTH) ? DIM_RESET : MAX_WIDTH;
  localparam int H_RST = (DIM_RESET < MAX_HEIGHT) ? DIM_RESET : MAX_HEIGHT;

  logic [WDW-1:0] width_q, width_d;
  logic [HDW-1:0] height_q, height_d;
  logic [CW-1:0]  col_q, col_d;
  logic [RW-1:0]  row_q, row_d;
  logic           accept, restart;
  logic           col_last, row_last;
  logic [CW-1:0]  col_m1;
  logic [RW-1:0]  row_m1;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = q_ready_i;
  assign accept      = in_valid_i && q_ready_i;
  assign restart     = (cfg_valid_i && (cfg_index_i == CFG_WIDTH || cfg_index_i == CFG_HEIGHT))
                    || (accept && opcode_i == OP_CLEAR);

  assign col_last = (WDW'(col_q) + WDW'(1)) == width_q;
  assign row_last = (HDW'(row_q) + HDW'(1)) == height_q;
  assign col_m1   = col_q - 1'b1;
  assign row_m1   = row_q - 1'b1;

  // classify the request
  always_comb begin
    q_push_o        = accept && (opcode_i == OP_PIXEL || opcode_i == OP_READ ||
                                 opcode_i == OP_CLEAR);
    q_item_o.kind   = K_PIXEL;
    if (opcode_i == OP_READ) begin
      q_item_o.kind = K_READ;
    end else if (opcode_i == OP_CLEAR) begin
      q_item_o.kind = K_CLEAR;
    end
    q_item_o.px     = pixel_value_i;
    q_item_o.bin    = bin_index_i;
    q_item_o.border = (row_q == '0) || (col_q == '0) || row_last || col_last;
    q_item_o.emit   = (row_q >= RW'(2)) && (col_q >= CW'(2));
    q_item_o.last   = row_last && col_last;
    q_item_o.row    = COORD_W'(row_m1);
    q_item_o.col    = COORD_W'(col_m1);
    q_ci_o          = col_q;
  end

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i) begin
      if (cfg_index_i == CFG_WIDTH) begin
        if (cfg_data_i < DIM_W'(DIM_MIN)) begin
          width_d = WDW'(DIM_MIN);
        end else if (32'(cfg_data_i) > 32'(MAX_WIDTH)) begin
          width_d = WDW'(MAX_WIDTH);
        end else begin
          width_d = WDW'(cfg_data_i);
        end
      end else if (cfg_index_i == CFG_HEIGHT) begin
        if (cfg_data_i < DIM_W'(DIM_MIN)) begin
          height_d = HDW'(DIM_MIN);
        end else if (32'(cfg_data_i) > 32'(MAX_HEIGHT)) begin
          height_d = HDW'(MAX_HEIGHT);
        end else begin
          height_d = HDW'(cfg_data_i);
        end
      end
    end
  end

  // raster position
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (restart) begin
      col_d = '0;
      row_d = '0;
    end else if (accept && opcode_i == OP_PIXEL) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WDW'(W_RST);
      height_q <= HDW'(H_RST);
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

endmodule

// File: hdl/lbpih_back.sv
module lbpih_back #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               q_valid_i,
  input  lbpih_pkg::item_t                   q_item_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]       q_ci_i,
  output logic                               q_pop_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               result_kind_o,
  output logic [lbpih_pkg::PIX_W-1:0]        pattern_code_o,
  output logic [lbpih_pkg::COORD_W-1:0]      centre_row_o,
  output logic [lbpih_pkg::COORD_W-1:0]      centre_col_o,
  output logic [lbpih_pkg::CNT_W-1:0]        bin_count_o,
  output logic                               frame_done_o
);

  import lbpih_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  logic                 adv;

  // line-store read stage
  logic                 sb_vld_q;
  item_t                sb_item_q;
  logic [CW-1:0]        sb_ci_q;
  logic [PIX_W-1:0]     up_rdata, mid_rdata;
  logic [PIX_W-1:0]     win_q [WIN_TAPS];
  logic [PIX_W-1:0]     code;
  logic                 line_we, win_we;
  logic [BIN_W-1:0]     hist_raddr;

  // histogram update stage
  logic                 sc_vld_q;
  item_t                sc_item_q;
  logic [BIN_W-1:0]     sc_addr_q;
  logic [CNT_W-1:0]     hist_rdata;
  logic [HIST_BINS-1:0] hv_q, hv_d;
  logic                 fwd_vld_q;
  logic [CNT_W-1:0]     fwd_cnt_q;
  logic [CNT_W-1:0]     cur, inc;
  logic                 hist_we;
  logic [CNT_W-1:0]     bcnt_q, bcnt_d;
  logic [CNT_W:0]       bin0_sum;
  logic [CNT_W-1:0]     rd_count;

  // output register
  logic                 out_vld_q, out_vld_d;
  logic                 kind_q, kind_d;
  logic [PIX_W-1:0]     code_q, code_d;
  logic [COORD_W-1:0]   row_q, row_d;
  logic [COORD_W-1:0]   col_q, col_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 done_q, done_d;

  assign adv     = !out_vld_q || out_ready_i;
  assign q_pop_o = adv && q_valid_i;

  lbpih_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (sb_ci_q),
    .wdata_i (mid_rdata),
    .re_i    (adv),
    .raddr_i (q_ci_i),
    .rdata_o (up_rdata)
  );

  lbpih_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (sb_ci_q),
    .wdata_i (sb_item_q.px),
    .re_i    (adv),
    .raddr_i (q_ci_i),
    .rdata_o (mid_rdata)
  );

  assign win_we  = adv && sb_vld_q && (sb_item_q.kind == K_PIXEL);
  assign line_we = win_we;

  // neighbour >= centre, bit 0 top-left going clockwise
  always_comb begin
    code[0] = win_q[0] >= win_q[3];
    code[1] = win_q[1] >= win_q[3];
    code[2] = up_rdata >= win_q[3];
    code[3] = mid_rdata >= win_q[3];
    code[4] = sb_item_q.px >= win_q[3];
    code[5] = win_q[5] >= win_q[3];
    code[6] = win_q[4] >= win_q[3];
    code[7] = win_q[2] >= win_q[3];
  end

  assign hist_raddr = (sb_item_q.kind == K_READ) ? sb_item_q.bin : code;

  lbpih_ram #(.WIDTH(CNT_W), .DEPTH(HIST_BINS)) u_hist (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (sc_addr_q),
    .wdata_i (inc),
    .re_i    (adv),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  // bypass covers a read of the bin that the preceding request is writing
  always_comb begin
    if (fwd_vld_q) begin
      cur = fwd_cnt_q;
    end else if (hv_q[sc_addr_q]) begin
      cur = hist_rdata;
    end else begin
      cur = '0;
    end
  end

  assign inc     = (cur == HIST_MAX) ? cur : cur + 1'b1;
  assign hist_we = adv && sc_vld_q && (sc_item_q.kind == K_PIXEL) && sc_item_q.emit;

  // border pixels are counted apart and folded into bin zero on read
  assign bin0_sum = {1'b0, bcnt_q} + {1'b0, cur};
  always_comb begin
    rd_count = cur;
    if (sc_addr_q == '0) begin
      rd_count = (bin0_sum > {1'b0, HIST_MAX}) ? HIST_MAX : bin0_sum[CNT_W-1:0];
    end
  end

  always_comb begin
    hv_d   = hv_q;
    bcnt_d = bcnt_q;
    if (adv && sc_vld_q) begin
      case (sc_item_q.kind)
        K_CLEAR: begin
          hv_d   = '0;
          bcnt_d = '0;
        end
        K_PIXEL: begin
          if (sc_item_q.emit) begin
            hv_d[sc_addr_q] = 1'b1;
          end
          if (sc_item_q.border && bcnt_q != HIST_MAX) begin
            bcnt_d = bcnt_q + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    kind_d    = kind_q;
    code_d    = code_q;
    row_d     = row_q;
    col_d     = col_q;
    cnt_d     = cnt_q;
    done_d    = done_q;
    if (adv) begin
      out_vld_d = 1'b0;
      if (sc_vld_q && sc_item_q.kind == K_PIXEL && sc_item_q.emit) begin
        out_vld_d = 1'b1;
        kind_d    = RESULT_CODE;
        code_d    = sc_addr_q;
        row_d     = sc_item_q.row;
        col_d     = sc_item_q.col;
        cnt_d     = '0;
        done_d    = sc_item_q.last;
      end else if (sc_vld_q && sc_item_q.kind == K_READ) begin
        out_vld_d = 1'b1;
        kind_d    = RESULT_BIN;
        code_d    = '0;
        row_d     = '0;
        col_d     = '0;
        cnt_d     = rd_count;
        done_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_vld_q  <= 1'b0;
      sc_vld_q  <= 1'b0;
      fwd_vld_q <= 1'b0;
      hv_q      <= '0;
      bcnt_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      hv_q      <= hv_d;
      bcnt_q    <= bcnt_d;
      out_vld_q <= out_vld_d;
      if (adv) begin
        sb_vld_q  <= q_pop_o;
        sc_vld_q  <= sb_vld_q;
        fwd_vld_q <= hist_we && (hist_raddr == sc_addr_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    code_q <= code_d;
    row_q  <= row_d;
    col_q  <= col_d;
    cnt_q  <= cnt_d;
    done_q <= done_d;
    if (adv) begin
      sb_item_q <= q_item_i;
      sb_ci_q   <= q_ci_i;
      sc_item_q <= sb_item_q;
      sc_addr_q <= hist_raddr;
      fwd_cnt_q <= inc;
    end
    if (win_we) begin
      win_q[0] <= win_q[1];
      win_q[1] <= up_rdata;
      win_q[2] <= win_q[3];
      win_q[3] <= mid_rdata;
      win_q[4] <= win_q[5];
      win_q[5] <= sb_item_q.px;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign result_kind_o  = kind_q;
  assign pattern_code_o = code_q;
  assign centre_row_o   = row_q;
  assign centre_col_o   = col_q;
  assign bin_count_o    = cnt_q;
  assign frame_done_o   = done_q;

endmodule

// File: hdl/lbp_image_with_histogram.sv
// 3x3 local binary pattern over a raster pixel stream, with a 256-bin code histogram.
// Input channel (in_valid_i/in_ready_o) takes one request per cycle: a pixel, a read
// of one histogram bin, or a clear that also restarts the frame. Unused opcode 3 is
// dropped. Output channel (out_valid_o/out_ready_i) returns a pattern code with its
// centre coordinates once the pixel below-right of an interior centre arrives, or the
// count of the requested bin.
// Configuration port sets width (index 0) and height (index 1); values are clamped to
// 3..MAX and a write restarts the frame. Write only while the block is idle.
// Throughput: one request per cycle, set by the single read-modify-write of the
// histogram memory per request (bypassed when consecutive requests hit one bin).
// An accepted request passes the queue, the line-store read, the histogram update and
// the output register before its result is valid.
// A two-entry queue sits between front and back end; when the receiver stalls the
// back end holds and in_ready_o drops once the queue is full.
// Reset: dimensions go to 10 (capped at MAX), position to the frame start, histogram to all zero
// at once (per-bin valid bits); no clearing pass. Line stores are not cleared.
module lbp_image_with_histogram #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lbpih_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lbpih_pkg::DIM_W-1:0]     cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      opcode_i,
  input  logic [lbpih_pkg::PIX_W-1:0]     pixel_value_i,
  input  logic [lbpih_pkg::BIN_W-1:0]     bin_index_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            result_kind_o,
  output logic [lbpih_pkg::PIX_W-1:0]     pattern_code_o,
  output logic [lbpih_pkg::COORD_W-1:0]   centre_row_o,
  output logic [lbpih_pkg::COORD_W-1:0]   centre_col_o,
  output logic [lbpih_pkg::CNT_W-1:0]     bin_count_o,
  output logic                            frame_done_o
);

  import lbpih_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int QW = $bits(item_t) + CW;

  logic          q_ready, q_push, q_valid, q_pop;
  item_t         fr_item, bk_item;
  logic [CW-1:0] fr_ci, bk_ci;
  logic [QW-1:0] q_wdata, q_rdata;

  lbpih_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .pixel_value_i (pixel_value_i),
    .bin_index_i   (bin_index_i),
    .q_ready_i     (q_ready),
    .q_push_o      (q_push),
    .q_item_o      (fr_item),
    .q_ci_o        (fr_ci)
  );

  assign q_wdata = {fr_ci, fr_item};

  lbpih_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  assign {bk_ci, bk_item} = q_rdata;

  lbpih_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_item_i       (bk_item),
    .q_ci_i         (bk_ci),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_kind_o  (result_kind_o),
    .pattern_code_o (pattern_code_o),
    .centre_row_o   (centre_row_o),
    .centre_col_o   (centre_col_o),
    .bin_count_o    (bin_count_o),
    .frame_done_o   (frame_done_o)
  );

endmodule
